// ===== rtl/psmf_pkg.sv =====
// shared types, register indexes and a sample helper for the pcm saturate, mute and fade block
`default_nettype none
package psmf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FRAC_SHIFT  = 3'd0;
  localparam logic [2:0] REG_STEREO      = 3'd1;
  localparam logic [2:0] REG_FADE_FRAMES = 3'd2;
  localparam logic [2:0] REG_GAIN_INC    = 3'd3;
  localparam logic [2:0] REG_MUTE_FRAMES = 3'd4;

  // register reset values
  localparam logic [4:0]  FRAC_SHIFT_RST  = 5'd0;
  localparam logic        STEREO_RST      = 1'b1;
  localparam logic [16:0] FADE_FRAMES_RST = 17'd28800;
  localparam logic [14:0] GAIN_INC_RST    = 15'd1;
  localparam logic [16:0] MUTE_FRAMES_RST = 17'd9600;

  // q15 gain ceiling and 16-bit saturation limits
  localparam logic [14:0]        GAIN_MAX = 15'h7FFF;
  localparam logic signed [31:0] SAT_MAX  = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN  = -32'sd32768;

  typedef struct packed {
    logic [4:0]  frac_shift;
    logic        stereo;
    logic [16:0] fade_frames;
    logic [14:0] gain_inc;
    logic [16:0] mute_frames;
  } cfg_t;

  // per-frame control decided at input transfer
  typedef struct packed {
    logic        last;
    logic        muted;
    logic        fading;
    logic [14:0] gain;
  } frame_ctl_t;

  // pipeline stage enables
  typedef struct packed {
    logic en1;
    logic en2;
  } pipe_en_t;

  // arithmetic right shift then saturate to 16 bits
  function automatic logic signed [15:0] shift_sat(input logic signed [31:0] x,
                                                   input logic [4:0] sh);
    logic signed [31:0] v;
    logic signed [15:0] r;
    v = x >>> sh;
    if (v > SAT_MAX) begin
      r = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psmf_ctrl.sv =====
// configuration registers and mute / fade sequencing for each frame
`default_nettype none
module psmf_ctrl import psmf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire pipe_en_t    en,
  output cfg_t             cfg,
  output frame_ctl_t       ctl_q,
  output logic             v1
);

  logic [16:0] mute_left;
  logic        fade_active;
  logic [16:0] fade_count;
  logic [14:0] fade_gain;

  logic [16:0] mute_left_next;
  logic        fade_active_next;
  logic [16:0] fade_count_next;
  logic [14:0] fade_gain_next;
  frame_ctl_t  ctl_next;

  logic [16:0] ml;
  logic        fa;
  logic [16:0] fc;
  logic [14:0] fg;
  logic [15:0] gain_sum;
  logic [16:0] cnt_inc;

  // apply arm requests, then pick mute, fade or pass-through
  always_comb begin
    ml = s_tuser[1] ? cfg.mute_frames : mute_left;
    fa = s_tuser[0] ? 1'b1 : fade_active;
    fc = s_tuser[0] ? '0 : fade_count;
    fg = s_tuser[0] ? '0 : fade_gain;
    gain_sum = {1'b0, fg} + {1'b0, cfg.gain_inc};
    cnt_inc  = fc + 17'd1;

    mute_left_next   = ml;
    fade_active_next = fa;
    fade_count_next  = fc;
    fade_gain_next   = fg;
    ctl_next.last    = s_tlast;
    ctl_next.muted   = 1'b0;
    ctl_next.fading  = 1'b0;
    ctl_next.gain    = fg;

    if (ml != '0) begin
      ctl_next.muted = 1'b1;
      mute_left_next = ml - 17'd1;
    end else if (fa) begin
      ctl_next.fading  = 1'b1;
      fade_gain_next   = gain_sum[15] ? GAIN_MAX : gain_sum[14:0];
      fade_count_next  = cnt_inc;
      fade_active_next = !(cnt_inc >= cfg.fade_frames);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frac_shift  <= FRAC_SHIFT_RST;
      cfg.stereo      <= STEREO_RST;
      cfg.fade_frames <= FADE_FRAMES_RST;
      cfg.gain_inc    <= GAIN_INC_RST;
      cfg.mute_frames <= MUTE_FRAMES_RST;
      mute_left       <= '0;
      fade_active     <= 1'b0;
      fade_count      <= '0;
      fade_gain       <= '0;
      v1              <= 1'b0;
    end else begin
      // register write transfer
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FRAC_SHIFT:  cfg.frac_shift  <= cfg_data[4:0];
          REG_STEREO:      cfg.stereo      <= cfg_data[0];
          REG_FADE_FRAMES: cfg.fade_frames <= cfg_data[16:0];
          REG_GAIN_INC:    cfg.gain_inc    <= cfg_data[14:0];
          REG_MUTE_FRAMES: cfg.mute_frames <= cfg_data[16:0];
          default: ;
        endcase
      end
      // state advances on each input transfer
      if (en.en1) begin
        v1 <= s_tvalid;
        if (s_tvalid) begin
          mute_left   <= mute_left_next;
          fade_active <= fade_active_next;
          fade_count  <= fade_count_next;
          fade_gain   <= fade_gain_next;
        end
      end
    end
  end

  // stage 1 control payload
  always_ff @(posedge clk) begin
    if (en.en1) begin
      ctl_q <= ctl_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psmf_lane.sv =====
// one channel lane: shift and saturate, then mute or q15 gain scaling
`default_nettype none
module psmf_lane import psmf_pkg::*; (
  input  wire logic               clk,
  input  wire pipe_en_t           en,
  input  wire logic               lane_on,
  input  wire logic [4:0]         frac_shift,
  input  wire logic signed [31:0] sample_in,
  input  wire frame_ctl_t         ctl_q,
  output logic signed [15:0]      result
);

  logic signed [15:0] sample_q;
  logic signed [31:0] prod;

  // stage 1: saturated sample, zero when the lane is off
  always_ff @(posedge clk) begin
    if (en.en1) begin
      sample_q <= lane_on ? shift_sat(sample_in, frac_shift) : '0;
    end
  end

  assign prod = 32'(sample_q) * 32'($signed({1'b0, ctl_q.gain}));

  // stage 2: silence, scaled or pass-through
  always_ff @(posedge clk) begin
    if (en.en2) begin
      if (ctl_q.muted) begin
        result <= '0;
      end else if (ctl_q.fading) begin
        result <= prod[30:15];
      end else begin
        result <= sample_q;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psmf_merge.sv =====
// output stage: joins lane results with the frame flags into one transfer
`default_nettype none
module psmf_merge import psmf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pipe_en_t    en,
  input  wire logic        v1,
  input  wire frame_ctl_t  ctl_q,
  input  wire logic [15:0] left_res,
  input  wire logic [15:0] right_res,
  output logic             m_tvalid,
  output logic [31:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic muted_q;
  logic fading_q;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en.en2) begin
      m_tvalid <= v1;
    end
  end

  // frame flags follow the lane results
  always_ff @(posedge clk) begin
    if (en.en2) begin
      muted_q  <= ctl_q.muted;
      fading_q <= ctl_q.fading;
      m_tlast  <= ctl_q.last;
    end
  end

  assign m_tdata = {right_res, left_res};
  assign m_tuser = {fading_q, muted_q};

endmodule
`default_nettype wire

// ===== rtl/pcm_saturate_mute_fade_in.sv =====
// top level: pcm saturation with mute and linear fade-in, two parallel lanes
// stage 1 registers the input transfer; stage 2, the output register, sets
//   output valid from stage 1
// throughput: one frame per cycle when not stalled; both pipeline stages take
//   a new frame whenever the stage ahead is free or moving
// reset: clears pipeline valids and mute/fade state, loads register defaults
`default_nettype none
module pcm_saturate_mute_fade_in import psmf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // left_in [31:0], right_in [63:32]
  input  wire logic [1:0]  s_tuser,  // arm_fade [0], arm_mute [1]
  input  wire logic        s_tlast,  // end_of_block
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // left_out [15:0], right_out [31:16]
  output logic [1:0]       m_tuser,  // muted [0], fading [1]
  output logic             m_tlast   // last_out
);

  cfg_t               cfg;
  frame_ctl_t         ctl_q;
  pipe_en_t           en;
  logic               v1;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;

  // stage enables: each stage moves when the one ahead is empty or moving
  assign en.en2    = !m_tvalid || m_tready;
  assign en.en1    = !v1 || en.en2;
  assign s_tready  = en.en1;
  assign cfg_ready = 1'b1;

  psmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .en        (en),
    .cfg       (cfg),
    .ctl_q     (ctl_q),
    .v1        (v1)
  );

  psmf_lane u_lane_left (
    .clk        (clk),
    .en         (en),
    .lane_on    (1'b1),
    .frac_shift (cfg.frac_shift),
    .sample_in  ($signed(s_tdata[31:0])),
    .ctl_q      (ctl_q),
    .result     (left_res)
  );

  psmf_lane u_lane_right (
    .clk        (clk),
    .en         (en),
    .lane_on    (cfg.stereo),
    .frac_shift (cfg.frac_shift),
    .sample_in  ($signed(s_tdata[63:32])),
    .ctl_q      (ctl_q),
    .result     (right_res)
  );

  psmf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v1        (v1),
    .ctl_q     (ctl_q),
    .left_res  (left_res),
    .right_res (right_res),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/psmf_checker.sv =====
// port-level checks for the pcm saturate, mute and fade block, bound to the top level
`default_nettype none
module psmf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // a muted frame carries silence on both channels
  a_muted_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("muted frame carries non-zero samples");

  // a frame is never both muted and faded
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("frame flagged both muted and fading");

  // no output transfer pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

  // an empty output side always takes an offered input transfer
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !m_tvalid |-> s_tready)
    else $error("input refused with the output side empty");

  // a stalled result holds until its transfer
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output changed");

endmodule

bind pcm_saturate_mute_fade_in psmf_checker u_psmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== test/pcm_saturate_mute_fade_in_test.sv =====
// self-checking testbench for the pcm saturate, mute and fade-in block
module pcm_saturate_mute_fade_in_test;
  import psmf_pkg::*;

  typedef struct packed {
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
    logic               arm_fade;
    logic               arm_mute;
    logic               eob;
  } frame_in_t;

  typedef struct packed {
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic        muted;
    logic        fading;
    logic        last_out;
  } frame_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // left_in [31:0], right_in [63:32]
  logic [1:0]  s_tuser = '0;  // arm_fade [0], arm_mute [1]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // left_out [15:0], right_out [31:16]
  logic [1:0]  m_tuser;       // muted [0], fading [1]
  logic        m_tlast;

  // idling percentages for the two stream sides
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;

  // predictor copy of the registers and of the mute and fade state
  cfg_t        shadow_cfg;
  logic [16:0] mute_left;
  logic        fade_on;
  logic [16:0] fade_count;
  logic [15:0] fade_gain;

  frame_out_t  pending_frames[$];

  int unsigned failures = 0;
  int unsigned frames_checked = 0;
  int unsigned muted_frames = 0;
  int unsigned faded_frames = 0;
  int unsigned setups = 0;

  pcm_saturate_mute_fade_in dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever begin
      #4 clk = ~clk;
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rx_stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // shift right arithmetically, then clamp to 16 bits
  function automatic logic signed [15:0] sat_sample(input logic signed [31:0] x,
                                                    input logic [4:0] sh);
    longint v;
    v = x;
    v = v >>> sh;
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // q15 gain, floor of the product
  function automatic logic signed [15:0] apply_gain(input logic signed [15:0] x,
                                                    input logic [15:0] g);
    longint p;
    p = x * $signed({1'b0, g});
    p = p >>> 15;
    return p[15:0];
  endfunction

  // work out the output frame of one accepted input frame
  task automatic predict_frame(input frame_in_t f);
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic [16:0]        gain_sum;
    frame_out_t         res;
    l = sat_sample(f.left_in, shadow_cfg.frac_shift);
    r = shadow_cfg.stereo ? sat_sample(f.right_in, shadow_cfg.frac_shift) : 16'sd0;
    res.muted = 1'b0;
    res.fading = 1'b0;
    if (f.arm_fade) begin
      fade_on = 1'b1;
      fade_count = '0;
      fade_gain = '0;
    end
    if (f.arm_mute) begin
      mute_left = shadow_cfg.mute_frames;
    end
    if (mute_left != 0) begin
      l = '0;
      r = '0;
      res.muted = 1'b1;
      mute_left = mute_left - 17'd1;
      muted_frames++;
    end else if (fade_on) begin
      l = apply_gain(l, fade_gain);
      r = apply_gain(r, fade_gain);
      res.fading = 1'b1;
      gain_sum = {1'b0, fade_gain} + {2'b00, shadow_cfg.gain_inc};
      fade_gain = (gain_sum > {2'b00, GAIN_MAX}) ? {1'b0, GAIN_MAX} : gain_sum[15:0];
      fade_count = fade_count + 17'd1;
      if (fade_count >= shadow_cfg.fade_frames) begin
        fade_on = 1'b0;
      end
      faded_frames++;
    end
    res.left_out = l;
    res.right_out = shadow_cfg.stereo ? r : 16'd0;
    res.last_out = f.eob;
    pending_frames.push_back(res);
  endtask

  // compare each output transfer with the oldest predicted frame
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("output transfer with no frame outstanding");
        failures++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (m_tdata[15:0] !== want.left_out) begin
          $error("left_out expected %0d got %0d", $signed(want.left_out),
                 $signed(m_tdata[15:0]));
          failures++;
        end
        if (m_tdata[31:16] !== want.right_out) begin
          $error("right_out expected %0d got %0d", $signed(want.right_out),
                 $signed(m_tdata[31:16]));
          failures++;
        end
        if (m_tuser[0] !== want.muted) begin
          $error("muted expected %0b got %0b", want.muted, m_tuser[0]);
          failures++;
        end
        if (m_tuser[1] !== want.fading) begin
          $error("fading expected %0b got %0b", want.fading, m_tuser[1]);
          failures++;
        end
        if (m_tlast !== want.last_out) begin
          $error("last_out expected %0b got %0b", want.last_out, m_tlast);
          failures++;
        end
      end
    end
  end

  // one input transfer, idle cycles in front drawn one cycle at a time
  task automatic send_frame(input frame_in_t f);
    while (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {f.right_in, f.left_in};
    s_tuser <= {f.arm_mute, f.arm_fade};
    s_tlast <= f.eob;
    do @(posedge clk); while (!s_tready);
    predict_frame(f);
  endtask

  function automatic frame_in_t pcm_frame(input logic [31:0] l, input logic [31:0] r,
                                          input logic af, input logic am,
                                          input logic eob);
    frame_in_t f;
    f.left_in = l;
    f.right_in = r;
    f.arm_fade = af;
    f.arm_mute = am;
    f.eob = eob;
    return f;
  endfunction

  // hold the input off until every predicted frame has come out
  task automatic drain_output();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAC_SHIFT:  shadow_cfg.frac_shift = value[4:0];
      REG_STEREO:      shadow_cfg.stereo = value[0];
      REG_FADE_FRAMES: shadow_cfg.fade_frames = value[16:0];
      REG_GAIN_INC:    shadow_cfg.gain_inc = value[14:0];
      REG_MUTE_FRAMES: shadow_cfg.mute_frames = value[16:0];
      default: ;
    endcase
  endtask

  // block must be idle here
  task automatic configure_block(input int unsigned fs, input int unsigned st,
                                 input int unsigned ff, input int unsigned fstep,
                                 input int unsigned mf);
    drain_output();
    write_reg(REG_FRAC_SHIFT, fs);
    write_reg(REG_STEREO, st);
    write_reg(REG_FADE_FRAMES, ff);
    write_reg(REG_GAIN_INC, fstep);
    write_reg(REG_MUTE_FRAMES, mf);
    cfg_valid <= 1'b0;
    setups++;
  endtask

  // saturation at the register defaults
  task automatic test_register_defaults();
    send_frame(pcm_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1));
    send_frame(pcm_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_8000, 32'hFFFF_7FFF, 1'b0, 1'b0, 1'b1));
  endtask

  // widest shift, then mono
  task automatic test_shift_and_mono();
    configure_block(31, 1, 28800, 1, 9600);
    send_frame(pcm_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b1));
    configure_block(16, 0, 28800, 1, 9600);
    send_frame(pcm_frame(32'h1234_5678, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h8000_0000, 32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0));
  endtask

  // both requests on one frame: silence first, then the ramp up to a clipped gain
  task automatic test_mute_then_fade();
    configure_block(4, 1, 4, 15'h4000, 2);
    send_frame(pcm_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0));
    repeat (5) begin
      send_frame(pcm_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    end
  endtask

  // zero length fade and zero gain step
  task automatic test_zero_fade();
    configure_block(0, 1, 0, 0, 0);
    send_frame(pcm_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b1, 1'b1, 1'b0));
    send_frame(pcm_frame(32'h0000_1234, 32'hFFFF_8000, 1'b0, 1'b0, 1'b1));
    configure_block(0, 1, 3, 0, 0);
    send_frame(pcm_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b1, 1'b0, 1'b0));
    send_frame(pcm_frame(32'hFFFF_8000, 32'h0000_7FFF, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_4000, 32'hFFFF_C000, 1'b0, 1'b0, 1'b0));
  endtask

  // longest counts, then shortened while a fade and a mute are in progress
  task automatic test_long_counts();
    configure_block(0, 1, 131071, 32767, 131071);
    send_frame(pcm_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b1, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'hFFFF_8000, 32'h0000_7FFF, 1'b0, 1'b1, 1'b0));
    send_frame(pcm_frame(32'hFFFF_8000, 32'h0000_7FFF, 1'b0, 1'b0, 1'b0));
    configure_block(0, 1, 1, 32767, 1);
    send_frame(pcm_frame(32'h0000_1000, 32'h0000_2000, 1'b0, 1'b1, 1'b0));
    send_frame(pcm_frame(32'h0000_1000, 32'h0000_2000, 1'b0, 1'b0, 1'b0));
    send_frame(pcm_frame(32'h0000_1000, 32'h0000_2000, 1'b0, 1'b0, 1'b1));
  endtask

  // full-range, scaled-down or clipping sample
  function automatic logic [31:0] random_sample();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      1, 2: v = v >>> $urandom_range(4, 31);
      3: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: ;
    endcase
    return v;
  endfunction

  // random register setting, mostly short mutes and fades
  task automatic random_setup();
    int unsigned fs;
    int unsigned ff;
    int unsigned fstep;
    int unsigned mf;
    fs = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 31 : 0) : $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: ff = 0;
      1: ff = 131071;
      2: ff = $urandom_range(1, 131071);
      default: ff = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 7))
      0: fstep = 0;
      1: fstep = 32767;
      2, 3: fstep = $urandom_range(1, 64);
      default: fstep = $urandom_range(1, 32767);
    endcase
    case ($urandom_range(0, 11))
      0: mf = 131071;
      1: mf = $urandom_range(0, 131071);
      default: mf = $urandom_range(0, 12);
    endcase
    configure_block(fs, $urandom_range(0, 1), ff, fstep, mf);
  endtask

  task automatic run_random_segment(input int unsigned count);
    frame_in_t f;
    for (int unsigned i = 0; i < count; i++) begin
      f.left_in = random_sample();
      f.right_in = random_sample();
      f.arm_fade = ($urandom_range(0, 23) == 0);
      f.arm_mute = ($urandom_range(0, 29) == 0);
      f.eob = ($urandom_range(0, 7) == 0);
      send_frame(f);
    end
  endtask

  // random traffic under one idling pattern, fresh settings per segment
  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    repeat (6) begin
      random_setup();
      run_random_segment(48);
    end
  endtask

  initial begin
    shadow_cfg.frac_shift = FRAC_SHIFT_RST;
    shadow_cfg.stereo = STEREO_RST;
    shadow_cfg.fade_frames = FADE_FRAMES_RST;
    shadow_cfg.gain_inc = GAIN_INC_RST;
    shadow_cfg.mute_frames = MUTE_FRAMES_RST;
    mute_left = '0;
    fade_on = 1'b0;
    fade_count = '0;
    fade_gain = '0;
    tx_gap_pct = 16;
    rx_stall_pct = 71;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_shift_and_mono();
    test_mute_then_fade();
    test_zero_fade();
    test_long_counts();
    test_random_traffic(16, 71);
    test_random_traffic(71, 16);
    test_random_traffic(0, 0);

    // let the last frames come out
    drain_output();
    repeat (8) @(posedge clk);

    $display("checked %0d frames: %0d silenced, %0d scaled by the ramp", frames_checked,
             muted_frames, faded_frames);
    $display("%0d register settings applied, mono and stereo, shifts 0 to 31", setups);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
